FILE: rtl/sqn_pkg.sv
// sqn_pkg: shared types and constants of the square/noise sound generator
// used by every rtl file of the block; depends on nothing
`default_nettype none

package sqn_pkg;

    localparam int WAVE_LENGTH_DEF      = 256;
    localparam int MAX_NOISE_SHIFTS_DEF = 32;

    localparam int RATIO_W   = 26;
    localparam int PERIOD_W  = 10;
    localparam int VOL_W     = 4;
    localparam int SAMPLE_W  = 7;
    localparam int LFSR_W    = 16;
    localparam int FRAC_W    = 16;
    localparam int NSTEP_W   = 21;
    localparam int DVR_W     = 15;
    localparam int CH_W      = 2;

    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(5319480);
    localparam logic [LFSR_W-1:0]  LFSR_SEED   = 16'h8000;
    localparam logic [VOL_W-1:0]   VOL_SILENT  = 4'hF;
    localparam logic [1:0]         NOISE_MODE_TONE2 = 2'd3;
    localparam logic [CH_W-1:0]    CH_NOISE    = 2'd3;
    localparam logic [CH_W-1:0]    CH_LAST_TONE = 2'd2;

    typedef enum logic {
        DIV_RECALC = 1'b0,
        DIV_WRAP   = 1'b1
    } div_kind_t;

    typedef struct packed {
        logic            apply_cmd;
        logic            smp_clear;
        logic [CH_W-1:0] ch;
        logic            tone_adv;
        logic            div_start;
        div_kind_t       div_kind;
        logic            div_store;
        logic            step_direct;
        logic            noise_begin;
        logic            noise_shift;
        logic            out_load;
    } sqn_cmd_t;

    typedef struct packed {
        logic [3:0] need;
        logic       div_done;
        logic       rc_div;
        logic       tone_on;
        logic       tone_wrap;
        logic       noise_on;
        logic       shifts_zero;
        logic       out_free;
    } sqn_stat_t;

endpackage

`default_nettype wire

FILE: rtl/sqn_div.sv
// sqn_div: restoring divider, one quotient bit per cycle
// depends on sqn_pkg for the divisor width
`default_nettype none

module sqn_div #(
    parameter int DVD_W = 34
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [DVD_W-1:0]          dividend,
    input  wire logic [sqn_pkg::DVR_W-1:0] divisor,
    output logic                           done,
    output logic [DVD_W-1:0]               quotient
);

    localparam int DVR_W = sqn_pkg::DVR_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVR_W-1:0] rem_reg;
    logic [DVR_W-1:0] dvr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVR_W:0]   shifted;
    logic             fits;
    logic [DVR_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign fits    = shifted >= {1'b0, dvr_reg};
    assign diff    = shifted - {1'b0, dvr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvr_reg  <= divisor;
            cnt_reg  <= CNT_W'(DVD_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DVR_W-1:0] : shifted[DVR_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/sqn_ctrl.sv
// sqn_ctrl: sequencer for command words, step recalculation and sample ticks
// depends on sqn_pkg for the command and status structs
`default_nettype none

module sqn_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              kind,
    input  wire sqn_pkg::sqn_stat_t stat,
    output sqn_pkg::sqn_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RC_PICK,
        ST_RC_WAIT,
        ST_TONE,
        ST_WRAP_WAIT,
        ST_NOISE,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [sqn_pkg::CH_W-1:0]   ch_reg;
    logic [sqn_pkg::CH_W-1:0]   ch_next;
    logic [sqn_pkg::CH_W-1:0]   need_first;
    logic                       accept;

    always_comb
    begin
        if (stat.need[0])
            need_first = 2'd0;
        else if (stat.need[1])
            need_first = 2'd1;
        else if (stat.need[2])
            need_first = 2'd2;
        else
            need_first = sqn_pkg::CH_NOISE;
    end

    assign in_ready = (state_reg == ST_IDLE) && (stat.need == 4'b0000);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.ch     = ch_reg;
        state_next = state_reg;
        ch_next    = ch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (stat.need != 4'b0000)
                begin
                    ch_next    = need_first;
                    state_next = ST_RC_PICK;
                end
                else if (accept && !kind)
                begin
                    cmd.apply_cmd = 1'b1;
                end
                else if (accept)
                begin
                    cmd.smp_clear = 1'b1;
                    ch_next       = '0;
                    state_next    = ST_TONE;
                end
            end
            ST_RC_PICK:
            begin
                cmd.div_kind = sqn_pkg::DIV_RECALC;
                if (stat.rc_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_RC_WAIT;
                end
                else
                begin
                    cmd.step_direct = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_RC_WAIT:
            begin
                cmd.div_kind = sqn_pkg::DIV_RECALC;
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_TONE:
            begin
                cmd.div_kind = sqn_pkg::DIV_WRAP;
                if (stat.tone_on)
                    cmd.tone_adv = 1'b1;
                if (stat.tone_on && stat.tone_wrap)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_WRAP_WAIT;
                end
                else if (ch_reg == sqn_pkg::CH_LAST_TONE)
                    state_next = ST_NOISE;
                else
                    ch_next = ch_reg + 1'b1;
            end
            ST_WRAP_WAIT:
            begin
                cmd.div_kind = sqn_pkg::DIV_WRAP;
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (ch_reg == sqn_pkg::CH_LAST_TONE)
                        state_next = ST_NOISE;
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_TONE;
                    end
                end
            end
            ST_NOISE:
            begin
                if (stat.noise_on)
                begin
                    cmd.noise_begin = 1'b1;
                    state_next      = ST_SHIFT;
                end
                else
                    state_next = ST_FINISH;
            end
            ST_SHIFT:
            begin
                if (!stat.shifts_zero)
                    cmd.noise_shift = 1'b1;
                else
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sqn_dp.sv
// sqn_dp: voice registers, phase accumulators, noise lfsr and output word
// depends on sqn_pkg and instantiates sqn_div
`default_nettype none

module sqn_dp #(
    parameter int WAVE_LENGTH      = sqn_pkg::WAVE_LENGTH_DEF,
    parameter int MAX_NOISE_SHIFTS = sqn_pkg::MAX_NOISE_SHIFTS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sqn_pkg::sqn_cmd_t                   cmd,
    output sqn_pkg::sqn_stat_t                       stat,
    input  wire logic [7:0]                          data_byte,
    input  wire logic                                cfg_we,
    input  wire logic [sqn_pkg::RATIO_W-1:0]         cfg_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [sqn_pkg::SAMPLE_W-1:0]      sample
);

    localparam int FRAC_W  = sqn_pkg::FRAC_W;
    localparam int RATIO_W = sqn_pkg::RATIO_W;
    localparam int NSTEP_W = sqn_pkg::NSTEP_W;
    localparam int DVR_W   = sqn_pkg::DVR_W;
    localparam int SAMPLE_W = sqn_pkg::SAMPLE_W;
    localparam int VOL_W   = sqn_pkg::VOL_W;
    localparam int PERIOD_W = sqn_pkg::PERIOD_W;
    localparam int LFSR_W  = sqn_pkg::LFSR_W;
    localparam int L       = $clog2(WAVE_LENGTH);
    localparam int PH_W    = L + FRAC_W;
    localparam int ST_W    = L + NSTEP_W;
    localparam int SUM_W   = ST_W + 1;
    localparam int DVD_W   = RATIO_W + L;
    localparam int CNT_W   = $clog2(MAX_NOISE_SHIFTS + 1);
    localparam int NT_W    = NSTEP_W + 1;
    localparam int XW      = SUM_W - FRAC_W;
    localparam int MOD_S   = XW + L;
    localparam logic [63:0] MOD_M =
        ((64'd1 << MOD_S) + 64'(WAVE_LENGTH) - 64'd1) / 64'(WAVE_LENGTH);
    localparam int MW      = $clog2(MOD_M + 64'd1);
    localparam int PW      = XW + MW;
    localparam logic [SUM_W-1:0] FULL = SUM_W'(WAVE_LENGTH) << FRAC_W;
    localparam logic [PH_W-1:0]  HALF = PH_W'(WAVE_LENGTH / 2) << FRAC_W;

    logic [RATIO_W-1:0]  ratio_reg;
    logic [VOL_W-1:0]    vol_reg [4];
    logic [PERIOD_W-1:0] period_reg [3];
    logic [1:0]          lc_reg;
    logic                liv_reg;
    logic [1:0]          mode_reg;
    logic                white_reg;
    logic [LFSR_W-1:0]   lfsr_reg;
    logic                nbit_reg;
    logic [FRAC_W-1:0]   nphase_reg;
    logic [PH_W-1:0]     tphase_reg [3];
    logic [ST_W-1:0]     tstep_reg [3];
    logic [NSTEP_W-1:0]  nstep_reg;
    logic [3:0]          need_reg;
    logic signed [SAMPLE_W-1:0] sum_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [XW-1:0]       mod_x_reg;
    logic [XW-1:0]       mod_q_reg;
    logic                mod_v1_reg;
    logic                mod_v2_reg;

    logic [1:0]          tsel;
    logic [SUM_W-1:0]    t_sum;
    logic signed [SAMPLE_W-1:0] t_lvl;
    logic signed [SAMPLE_W-1:0] t_part;
    logic signed [SAMPLE_W-1:0] n_lvl;
    logic signed [SAMPLE_W-1:0] n_part;
    logic signed [SAMPLE_W-1:0] out_value;
    logic [NT_W-1:0]     n_total;
    logic [5:0]          n_whole;
    logic [LFSR_W-1:0]   lfsr_rot;
    logic [NSTEP_W-1:0]  n_direct;
    logic [DVD_W-1:0]    dvd;
    logic [DVR_W-1:0]    dvr;
    logic                div_start;
    logic                div_done;
    logic [DVD_W-1:0]    div_q;
    logic                mod_start;
    logic [PW-1:0]       mod_prod;
    logic [XW-1:0]       mod_qw;
    logic [XW-1:0]       mod_rem;
    logic                is_latch;
    logic [1:0]          byte_ch;
    logic                out_free;

    assign tsel   = (cmd.ch == sqn_pkg::CH_NOISE) ? sqn_pkg::CH_LAST_TONE : cmd.ch;
    assign t_sum  = SUM_W'(tphase_reg[tsel]) + SUM_W'(tstep_reg[tsel]);
    assign t_lvl  = $signed({{(SAMPLE_W-VOL_W){1'b0}}, sqn_pkg::VOL_SILENT - vol_reg[tsel]});
    assign t_part = (tphase_reg[tsel] < HALF) ? t_lvl : -t_lvl;
    assign n_lvl  = $signed({{(SAMPLE_W-VOL_W){1'b0}}, sqn_pkg::VOL_SILENT - vol_reg[3]});
    assign n_part = nbit_reg ? n_lvl : -n_lvl;
    assign out_value = stat.noise_on ? sum_reg + n_part : sum_reg;

    assign n_total = NT_W'(nphase_reg) + NT_W'(nstep_reg);
    assign n_whole = n_total[NT_W-1:FRAC_W];

    // rotate right, then fold bit 6 into the top bit for white noise
    always_comb
    begin
        lfsr_rot = {lfsr_reg[0], lfsr_reg[LFSR_W-1:1]};
        if (white_reg && lfsr_rot[6])
            lfsr_rot[LFSR_W-1] = ~lfsr_rot[LFSR_W-1];
    end

    assign n_direct = (mode_reg == sqn_pkg::NOISE_MODE_TONE2) ? '0 :
                      NSTEP_W'(ratio_reg >> (5'd9 + {3'b000, mode_reg}));

    always_comb
    begin
        dvr = {period_reg[tsel], 5'b00000};
        if (cmd.ch == sqn_pkg::CH_NOISE)
            dvd = DVD_W'(ratio_reg);
        else
            dvd = DVD_W'(ratio_reg) * DVD_W'(WAVE_LENGTH);
    end

    assign div_start = cmd.div_start && (cmd.div_kind == sqn_pkg::DIV_RECALC);
    assign mod_start = cmd.div_start && (cmd.div_kind == sqn_pkg::DIV_WRAP);

    sqn_div #(
        .DVD_W (DVD_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dvd),
        .divisor   (dvr),
        .done      (div_done),
        .quotient  (div_q)
    );

    // integer part mod wave length: reciprocal multiply gives the exact
    // quotient for every XW-bit value, then one multiply-subtract
    assign mod_prod = PW'(mod_x_reg) * PW'(MOD_M);
    assign mod_qw   = mod_q_reg * XW'(WAVE_LENGTH);
    assign mod_rem  = mod_x_reg - mod_qw;

    assign is_latch = data_byte[7];
    assign byte_ch  = is_latch ? data_byte[6:5] : lc_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        stat             = '0;
        stat.need        = need_reg;
        stat.div_done    = div_done || mod_v2_reg;
        stat.rc_div      = (cmd.ch == sqn_pkg::CH_NOISE) ?
                           (mode_reg == sqn_pkg::NOISE_MODE_TONE2 && period_reg[2] != '0) :
                           (period_reg[tsel] != '0);
        stat.tone_on     = (vol_reg[tsel] != sqn_pkg::VOL_SILENT) && (period_reg[tsel] != '0);
        stat.tone_wrap   = t_sum >= FULL;
        stat.noise_on    = vol_reg[3] != sqn_pkg::VOL_SILENT;
        stat.shifts_zero = cnt_reg == '0;
        stat.out_free    = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg     <= sqn_pkg::RATIO_RESET;
            for (int i = 0; i < 4; i++)
                vol_reg[i] <= sqn_pkg::VOL_SILENT;
            for (int i = 0; i < 3; i++)
            begin
                period_reg[i] <= '0;
                tphase_reg[i] <= '0;
                tstep_reg[i]  <= '0;
            end
            lc_reg        <= '0;
            liv_reg       <= 1'b0;
            mode_reg      <= '0;
            white_reg     <= 1'b0;
            lfsr_reg      <= sqn_pkg::LFSR_SEED;
            nbit_reg      <= 1'b0;
            nphase_reg    <= '0;
            nstep_reg     <= '0;
            need_reg      <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            mod_v1_reg    <= 1'b0;
            mod_v2_reg    <= 1'b0;
        end
        else
        begin
            mod_v1_reg <= mod_start;
            mod_v2_reg <= mod_v1_reg;

            // step recalculation done for the selected voice
            if (cmd.step_direct ||
                (cmd.div_store && cmd.div_kind == sqn_pkg::DIV_RECALC))
            begin
                need_reg[cmd.ch] <= 1'b0;
                if (cmd.ch == sqn_pkg::CH_NOISE)
                    nstep_reg <= cmd.step_direct ? n_direct : NSTEP_W'(div_q);
                else
                    tstep_reg[tsel] <= cmd.step_direct ? '0 : ST_W'(div_q);
            end

            if (cfg_we)
            begin
                ratio_reg <= cfg_data;
                need_reg  <= 4'b1111;
            end

            if (cmd.apply_cmd)
            begin
                if (is_latch)
                begin
                    lc_reg  <= data_byte[6:5];
                    liv_reg <= data_byte[4];
                end
                if ((is_latch && data_byte[4]) || (!is_latch && liv_reg))
                    vol_reg[byte_ch] <= data_byte[3:0];
                else if (byte_ch == sqn_pkg::CH_NOISE)
                begin
                    if (is_latch)
                    begin
                        mode_reg    <= data_byte[1:0];
                        white_reg   <= data_byte[2];
                        lfsr_reg    <= sqn_pkg::LFSR_SEED;
                        need_reg[3] <= 1'b1;
                    end
                end
                else
                begin
                    if (is_latch)
                        period_reg[byte_ch][3:0] <= data_byte[3:0];
                    else
                        period_reg[byte_ch][9:4] <= data_byte[5:0];
                    need_reg[byte_ch] <= 1'b1;
                    if (byte_ch == sqn_pkg::CH_LAST_TONE)
                        need_reg[3] <= 1'b1;
                end
            end

            if (cmd.smp_clear)
                sum_reg <= '0;

            if (cmd.tone_adv)
            begin
                sum_reg <= sum_reg + t_part;
                if (!stat.tone_wrap)
                    tphase_reg[tsel] <= t_sum[PH_W-1:0];
            end

            // wrap: integer part mod wave length, fraction dropped
            if (cmd.div_store && cmd.div_kind == sqn_pkg::DIV_WRAP)
                tphase_reg[tsel] <= {mod_rem[L-1:0], {FRAC_W{1'b0}}};

            if (cmd.noise_begin)
            begin
                nphase_reg <= n_total[FRAC_W-1:0];
                if (32'(n_whole) > MAX_NOISE_SHIFTS)
                    cnt_reg <= CNT_W'(MAX_NOISE_SHIFTS);
                else
                    cnt_reg <= CNT_W'(n_whole);
            end

            if (cmd.noise_shift)
            begin
                nbit_reg <= lfsr_reg[0];
                lfsr_reg <= lfsr_rot;
                cnt_reg  <= cnt_reg - 1'b1;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            sample_reg <= out_value;
        if (mod_start)
            mod_x_reg <= t_sum[SUM_W-1:FRAC_W];
        if (mod_v1_reg)
            mod_q_reg <= XW'(mod_prod >> MOD_S);
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule

`default_nettype wire

FILE: rtl/square_noise_sound_generator.sv
// square_noise_sound_generator: top level of the four-voice sound generator
// depends on sqn_pkg, sqn_ctrl and sqn_dp
//
// input channel (in_valid/in_ready) takes one word: kind 0 carries a command
// byte in data_byte, kind 1 is a sample tick. each tick yields one output word
// on (out_valid/out_ready): sample, the signed sum of the voice levels.
// cfg_we writes clock_ratio from cfg_data; all step sizes are recomputed after.
// one word is processed at a time. a command byte is accepted, then comes
// one step recomputation per changed voice, either without division or
// with the serial divider.
// a clock_ratio write recomputes all four voices back to back.
// a sample tick is accepted, then passes the tone state for each of the three
// tone voices, a wrap wait for each sounding voice whose phase wraps, the
// noise state, for an audible noise voice the shift state with up to
// MAX_NOISE_SHIFTS lfsr shifts, and the output load; output valid the cycle after.
// the output register holds the word while out_ready is low; the next input
// word is still taken, and a tick finishing meanwhile waits for the register.
// reset restores silent voices, zero periods and steps, and the default ratio.
`default_nettype none

module square_noise_sound_generator #(
    parameter int WAVE_LENGTH      = sqn_pkg::WAVE_LENGTH_DEF,
    parameter int MAX_NOISE_SHIFTS = sqn_pkg::MAX_NOISE_SHIFTS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                kind,
    input  wire logic [7:0]                          data_byte,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [sqn_pkg::SAMPLE_W-1:0]      sample,
    input  wire logic                                cfg_we,
    input  wire logic [sqn_pkg::RATIO_W-1:0]         cfg_data
);

    sqn_pkg::sqn_cmd_t  cmd;
    sqn_pkg::sqn_stat_t stat;

    sqn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .stat     (stat),
        .cmd      (cmd)
    );

    sqn_dp #(
        .WAVE_LENGTH      (WAVE_LENGTH),
        .MAX_NOISE_SHIFTS (MAX_NOISE_SHIFTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .data_byte (data_byte),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_square_noise_sound_generator.sv
// tb_square_noise_sound_generator: self-checking bench for the sound generator
// depends on sqn_pkg and square_noise_sound_generator; predicts each sample word
`timescale 1ns / 1ps

module tb_square_noise_sound_generator;

    localparam int WAVE_LEN   = sqn_pkg::WAVE_LENGTH_DEF;
    localparam int MAX_SHIFTS = sqn_pkg::MAX_NOISE_SHIFTS_DEF;
    localparam int SAMPLE_W   = sqn_pkg::SAMPLE_W;
    localparam int RATIO_W    = sqn_pkg::RATIO_W;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 400;

    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = 1'b0;
    logic [7:0] data_byte = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] sample;
    logic cfg_we = 1'b0;
    logic [RATIO_W-1:0] cfg_data = '0;

    square_noise_sound_generator u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .sample(sample),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } psg_word_t;

    // predictor state
    logic [63:0] m_ratio;
    logic [3:0]  m_vol [4];
    logic [9:0]  m_period [3];
    logic [1:0]  m_latch_ch;
    logic        m_latch_vol;
    logic [1:0]  m_nmode;
    logic        m_nwhite;
    logic [15:0] m_lfsr;
    logic        m_nbit;
    logic [63:0] m_nphase;
    logic [63:0] m_phase [3];
    logic [63:0] m_step [3];
    logic [63:0] m_nstep;

    psg_word_t pending_words[$];
    logic signed [SAMPLE_W-1:0] expected_samples[$];
    int  errors = 0;
    int  cycles = 0;
    bit  quiet_in = 0, quiet_out = 0;
    bit  hold_input = 0;

    function automatic logic [63:0] tone_step_of(logic [9:0] p);
        if (p == 0) return 64'd0;
        return (m_ratio * WAVE_LEN) / (64'd32 * p);
    endfunction

    task automatic recalc_noise_step();
        if (m_nmode != sqn_pkg::NOISE_MODE_TONE2)
            m_nstep = m_ratio >> (9 + m_nmode);
        else
            m_nstep = (m_period[2] == 0) ? 64'd0 : m_ratio / (64'd32 * m_period[2]);
    endtask

    task automatic set_period(int ch, logic [9:0] p);
        m_period[ch] = p;
        m_step[ch] = tone_step_of(p);
        if (ch == 2) recalc_noise_step();
    endtask

    task automatic model_reset();
        m_ratio = sqn_pkg::RATIO_RESET;
        for (int i = 0; i < 4; i++) m_vol[i] = sqn_pkg::VOL_SILENT;
        for (int i = 0; i < 3; i++)
        begin
            m_period[i] = 0; m_phase[i] = 0; m_step[i] = 0;
        end
        m_latch_ch = 0; m_latch_vol = 0; m_nmode = 0; m_nwhite = 0;
        m_lfsr = sqn_pkg::LFSR_SEED; m_nbit = 0; m_nphase = 0; m_nstep = 0;
    endtask

    task automatic model_ratio(logic [RATIO_W-1:0] r);
        m_ratio = r;
        for (int i = 0; i < 3; i++) m_step[i] = tone_step_of(m_period[i]);
        recalc_noise_step();
    endtask

    task automatic apply_command(logic [7:0] b);
        logic [1:0] ch;
        if (b[7])
        begin
            ch = b[6:5];
            m_latch_ch = ch;
            m_latch_vol = b[4];
            if (b[4])
                m_vol[ch] = b[3:0];
            else if (ch == sqn_pkg::CH_NOISE)
            begin
                m_nmode = b[1:0]; m_nwhite = b[2]; m_lfsr = sqn_pkg::LFSR_SEED;
                recalc_noise_step();
            end
            else
                set_period(ch, {m_period[ch][9:4], b[3:0]});
        end
        else
        begin
            ch = m_latch_ch;
            if (m_latch_vol)
                m_vol[ch] = b[3:0];
            else if (ch != sqn_pkg::CH_NOISE)
                set_period(ch, {b[5:0], m_period[ch][3:0]});
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] mix_sample();
        int sum, lvl;
        logic [63:0] total, shifts;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            lvl = 15 - int'(m_vol[i]);
            if (m_vol[i] != sqn_pkg::VOL_SILENT && m_period[i] != 0)
            begin
                sum += (m_phase[i] < (64'(WAVE_LEN / 2) << 16)) ? lvl : -lvl;
                m_phase[i] += m_step[i];
                if (m_phase[i] >= (64'(WAVE_LEN) << 16))
                    m_phase[i] = ((m_phase[i] >> 16) % WAVE_LEN) << 16;
            end
        end
        if (m_vol[3] != sqn_pkg::VOL_SILENT)
        begin
            lvl = 15 - int'(m_vol[3]);
            total = m_nphase + m_nstep;
            shifts = total >> 16;
            if (shifts > MAX_SHIFTS) shifts = MAX_SHIFTS;
            m_nphase = total & 64'hFFFF;
            for (int k = 0; k < shifts; k++)
            begin
                m_nbit = m_lfsr[0];
                m_lfsr = {m_lfsr[0], m_lfsr[15:1]};
                if (m_nwhite && m_lfsr[6]) m_lfsr[15] = ~m_lfsr[15];
            end
            sum += m_nbit ? lvl : -lvl;
        end
        return SAMPLE_W'(sum);
    endfunction

    // driver: presents queued words, predicts on acceptance
    always @(posedge clk)
    begin
        psg_word_t w;
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (kind == KIND_TICK)
                    expected_samples.push_back(mix_sample());
                else
                    apply_command(data_byte);
            end
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() > 0 && !hold_input
                    && (quiet_in || $urandom_range(99) >= 10))
                begin
                    w = pending_words.pop_front();
                    in_valid <= 1'b1;
                    kind <= w.kind;
                    data_byte <= w.data;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= quiet_out || ($urandom_range(99) >= 10);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        logic signed [SAMPLE_W-1:0] exp_s;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected sample word, expected none, actual %0d",
                         $time, sample);
                errors++;
            end
            else
            begin
                exp_s = expected_samples.pop_front();
                if (sample !== exp_s)
                begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, exp_s, sample);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_cmd(logic [7:0] b);
        pending_words.push_back('{KIND_CMD, b});
    endtask

    task automatic push_ticks(int n);
        for (int i = 0; i < n; i++) pending_words.push_back('{KIND_TICK, 8'($urandom)});
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || in_valid || expected_samples.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_ratio(logic [RATIO_W-1:0] r);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= r;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_ratio(r);
    endtask

    // random program: ticks interleaved with commands, mostly well-formed latch/data pairs
    task automatic random_phase(int n);
        int ch;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: push_cmd(8'($urandom));
                1, 2:
                begin
                    ch = $urandom_range(3);
                    push_cmd({1'b1, 2'(ch), 1'b1, 4'($urandom_range(14))});
                end
                3, 4:
                begin
                    ch = $urandom_range(3);
                    push_cmd({1'b1, 2'(ch), 1'b0, 4'($urandom)});
                    if ($urandom_range(1)) push_cmd({2'b00, 6'($urandom)});
                end
                default: push_ticks(1);
            endcase
        end
    endtask

    initial
    begin
        model_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset silence, extremes, each voice and noise type
        push_ticks(2);
        push_cmd(8'h90); push_cmd(8'h80); push_cmd(8'h01);
        push_ticks(3);
        push_cmd(8'hB7); push_cmd(8'hAF); push_cmd(8'h3F);
        push_cmd(8'hD0); push_cmd(8'hCF); push_cmd(8'h00);
        push_cmd(8'hF0); push_cmd(8'hE7);
        push_ticks(3);
        push_cmd(8'hE3); push_cmd(8'hE4); push_cmd(8'h15);
        push_cmd(8'hFF); push_cmd(8'hF8);
        push_ticks(3);
        drain();

        write_ratio(RATIO_W'(1));
        random_phase(60);
        drain();
        write_ratio({RATIO_W{1'b1}});
        quiet_in = 1; quiet_out = 1;
        random_phase(100);
        drain();
        quiet_in = 0; quiet_out = 0;
        write_ratio(RATIO_W'(0));
        random_phase(40);
        drain();
        write_ratio(RATIO_W'($urandom_range(200000, 12000000)));
        random_phase(100);
        // sender holds off until all samples are out
        hold_input = 1;
        while (expected_samples.size() > 0 || in_valid) @(posedge clk);
        hold_input = 0;
        random_phase(100);
        drain();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
